>>> rtl/gf2ivc_pkg.sv
// Package for the GF(2) innovative vector check: sizes, types and the cell token.
// Used by every module of the block; depends on nothing.
package gf2ivc_pkg;
  localparam int VectorBits = 40;
  localparam int Receivers = 16;
  localparam int RxW = 4;
  localparam int RankW = 6;
  localparam int RxIdxW = (Receivers > 1) ? $clog2(Receivers) : 1;

  typedef logic [VectorBits-1:0] vec_t;
  typedef logic [RankW-1:0] rank_t;

  typedef enum logic {
    OpInsert = 1'b0,
    OpClear  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDone
  } state_e;

  // Token passed from cell to cell along the reduction chain.
  typedef struct packed {
    logic tok_valid;
    vec_t vec;
  } tok_t;
endpackage

>>> rtl/gf2ivc_cell.sv
// One pivot cell of the reduction chain: holds the basis rows for one bit position.
// Depends on gf2ivc_pkg.
module gf2ivc_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [gf2ivc_pkg::RxIdxW-1:0]    rx_i,
  input  logic                             clear_i,
  input  gf2ivc_pkg::tok_t                 tok_i,
  input  logic                             bit_i,
  input  logic                             store_i,
  input  gf2ivc_pkg::vec_t                 store_vec_i,
  output gf2ivc_pkg::tok_t                 tok_o
);
  import gf2ivc_pkg::*;

  vec_t rows_q [Receivers];
  logic [Receivers-1:0] valid_q;
  tok_t tok_q;

  assign tok_o = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      tok_q <= '0;
    end else begin
      tok_q.tok_valid <= tok_i.tok_valid;
      if (bit_i && valid_q[rx_i]) begin
        tok_q.vec <= tok_i.vec ^ rows_q[rx_i];
      end else begin
        tok_q.vec <= tok_i.vec;
      end
      if (clear_i) begin
        valid_q[rx_i] <= 1'b0;
      end else if (store_i) begin
        valid_q[rx_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_i) begin
      rows_q[rx_i] <= store_vec_i;
    end
  end
endmodule

>>> rtl/gf2ivc_chain.sv
// Row of pivot cells, one per bit; the running vector walks one cell per cycle.
// Depends on gf2ivc_pkg and gf2ivc_cell.
module gf2ivc_chain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gf2ivc_pkg::RxIdxW-1:0] rx_i,
  input  logic                          clear_i,
  input  logic                          start_i,
  input  gf2ivc_pkg::vec_t              vec_i,
  output logic                          done_o,
  output gf2ivc_pkg::vec_t              rem_o,
  input  logic                          store_i
);
  import gf2ivc_pkg::*;

  tok_t tok_in [VectorBits];
  tok_t tok_out [VectorBits];

  // Leading bit of the remainder as a one-hot mask.
  logic [VectorBits-1:0] lead;
  always_comb begin
    lead = '0;
    for (int p = 0; p < VectorBits; p++) begin
      lead[p] = rem_o[p] && ((rem_o >> p) == vec_t'(1));
    end
  end

  // Cell p (p counts down from the top bit) sees the vector in the cycle after cell p+1 does.
  for (genvar p = 0; p < VectorBits; p++) begin : g_cell
    if (p == VectorBits - 1) begin : g_top
      assign tok_in[p] = {start_i, vec_i};
    end else begin : g_mid
      assign tok_in[p] = tok_out[p+1];
    end

    gf2ivc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .rx_i        (rx_i),
      .clear_i     (clear_i),
      .tok_i       (tok_in[p]),
      .bit_i       (tok_in[p].vec[p]),
      .store_i     (store_i && lead[p]),
      .store_vec_i (rem_o),
      .tok_o       (tok_out[p])
    );
  end

  assign done_o = tok_out[0].tok_valid;
  assign rem_o = tok_out[0].vec;
endmodule

>>> rtl/gf2_innovative_vector_check_top.sv
// Top level of the GF(2) innovative vector check: control, rank counts, output register.
// Depends on gf2ivc_pkg and gf2ivc_chain.
//
//   port group    direction  handshake           fields
//   input words   in         in_valid/in_stall   opcode, receiver, coeff_vector
//   result words  out        out_valid/out_stall independent, rank_after, full_res
//
// An insert, when its result is not stalled, runs as follows before the next word is
// accepted: the vector walks the chain of pivot cells, one cell per clock, the remainder
// is stored and the result registered together once it leaves the last cell, and the
// result is then taken from the output register.
// A clear or an out-of-range receiver skips the chain and goes straight to the result.
// Reset clears all pivot marks and ranks; basis rows are not reset.
// One word is in flight; in_stall_o is high until its result is taken.
module gf2_innovative_vector_check_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic [gf2ivc_pkg::RxW-1:0]   receiver_i,
  input  gf2ivc_pkg::vec_t             coeff_vector_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         independent_o,
  output gf2ivc_pkg::rank_t            rank_after_o,
  output logic                         full_res_o
);
  import gf2ivc_pkg::*;

  state_e state_q, state_d;
  logic [RxIdxW-1:0] rx_q;
  logic rx_ok;
  rank_t rank_q [Receivers];
  logic start, clear, store, done;
  vec_t rem;
  logic indep_q, full_q;
  rank_t rank_out_q;
  logic out_valid_q;
  logic [RxIdxW-1:0] rx_sel;

  assign rx_ok = ({2'b0, receiver_i} < 6'(Receivers));
  assign rx_sel = RxIdxW'(receiver_i);
  assign in_stall_o = (state_q != StIdle);
  assign start = in_valid_i && !in_stall_o && rx_ok && (op_e'(opcode_i) == OpInsert);
  assign clear = in_valid_i && !in_stall_o && rx_ok && (op_e'(opcode_i) == OpClear);
  assign store = done && (rem != '0);

  gf2ivc_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (start || clear ? rx_sel : rx_q),
    .clear_i (clear),
    .start_i (start),
    .vec_i   (coeff_vector_i),
    .done_o  (done),
    .rem_o   (rem),
    .store_i (store)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_valid_i) state_d = start ? StRun : StDone;
      StRun:  if (done) state_d = StDone;
      StDone: if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
      for (int r = 0; r < Receivers; r++) rank_q[r] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle && in_valid_i) begin
        out_valid_q <= !start;
      end else if (state_q == StRun && done) begin
        out_valid_q <= 1'b1;
      end else if (state_q == StDone && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (clear) rank_q[rx_sel] <= '0;
      if (store && rank_q[rx_q] < rank_t'(VectorBits)) begin
        rank_q[rx_q] <= rank_q[rx_q] + rank_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      rx_q <= rx_sel;
      indep_q <= 1'b0;
      rank_out_q <= '0;
      full_q <= 1'b0;
    end else if (state_q == StRun && done) begin
      indep_q <= store;
      if (store && rank_q[rx_q] < rank_t'(VectorBits)) begin
        rank_out_q <= rank_q[rx_q] + rank_t'(1);
        full_q <= (rank_q[rx_q] + rank_t'(1)) == rank_t'(VectorBits);
      end else begin
        rank_out_q <= rank_q[rx_q];
        full_q <= rank_q[rx_q] == rank_t'(VectorBits);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign independent_o = indep_q;
  assign rank_after_o = rank_out_q;
  assign full_res_o = full_q;
endmodule
